>>> sv/mldf_pkg.sv
// Shared types and constants for the masked Laplacian diffusion step core.
package mldf_pkg;

	localparam int DEF_MAX_X = 32;
	localparam int DEF_MAX_Y = 32;
	localparam int DEF_MAX_Z = 32;

	localparam int VAL_W     = 32;
	localparam int KIND_W    = 2;
	localparam int WORD_W    = VAL_W + KIND_W;
	localparam int COORD_W   = 5;
	localparam int SIZE_W    = 6;
	localparam int CFG_IDX_W = 3;
	localparam int COEF_W    = 32;
	localparam int FRAC_W    = 16;

	// per-axis neighbor difference sum, signed
	localparam int DIFF_W = 34;
	// multiplier magnitude operand, split in two chunks
	localparam int MAG_W  = 49;
	localparam int LO_W   = 25;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int FULL_W = MAG_W + COEF_W;
	localparam int RND_W  = FULL_W - FRAC_W;
	// signed product after cap
	localparam int RES_W  = 54;

	localparam logic [FULL_W-1:0] ROUND_HALF = FULL_W'(32'h0000_8000);
	localparam logic [RND_W-1:0]  PROD_CAP   = RND_W'(1) << 52;
	localparam logic [MAG_W-1:0]  LAP_CAP    = MAG_W'(1) << 48;

	localparam logic [KIND_W-1:0] KIND_FLUID = 2'd0;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_Z  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd6;

	localparam logic [COEF_W-1:0] RST_STEP = 32'd0;
	localparam logic [COEF_W-1:0] RST_INV  = 32'h0001_0000;
	localparam logic [SIZE_W-1:0] RST_SIZE = 6'd32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_FIN,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic              neg;
		logic [MAG_W-1:0]  mag;
		logic [COEF_W-1:0] coef;
	} mul_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [RES_W-1:0] value;
	} mul_rsp_t;

endpackage

>>> sv/masked_laplacian_diffusion_step_core.sv
// Top level: command sequencer, configuration registers and update datapath.
//
//  channel | signals                                      | handshake
//  --------+----------------------------------------------+------------------------------
//  command | start busy req_type cell_x/y/z value kind    | taken when start && !busy
//  result  | done new_value status                        | one-cycle strobe on done
//  config  | cfg_valid cfg_ready cfg_index cfg_data       | written when valid && ready
//
//  An out-of-range query strobes done in the cycle after it is taken. A query of a non-fluid
//  cell strobes it after the centre read is checked in ST_READ, a fluid cell after seven serial
//  reads of the single-port grid memory, then four products through the 4-stage multiplier.
//  busy drops in the strobe cycle; the next item can be taken there. Reset clears control
//  and configuration; grid contents are undefined until written. Results cannot be stalled.
module masked_laplacian_diffusion_step_core #(
	parameter int MAX_X = mldf_pkg::DEF_MAX_X,
	parameter int MAX_Y = mldf_pkg::DEF_MAX_Y,
	parameter int MAX_Z = mldf_pkg::DEF_MAX_Z
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  req_type,
	input  logic [mldf_pkg::COORD_W-1:0]          cell_x,
	input  logic [mldf_pkg::COORD_W-1:0]          cell_y,
	input  logic [mldf_pkg::COORD_W-1:0]          cell_z,
	input  logic signed [mldf_pkg::VAL_W-1:0]     cell_value,
	input  logic [mldf_pkg::KIND_W-1:0]           cell_kind,
	output logic                                  done,
	output logic signed [mldf_pkg::VAL_W-1:0]     new_value,
	output logic                                  status,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mldf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mldf_pkg::COEF_W-1:0]           cfg_data
);
	import mldf_pkg::*;

	localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] STRIDE_X = AW'(1);
	localparam logic [AW-1:0] STRIDE_Y = AW'(MAX_X);
	localparam logic [AW-1:0] STRIDE_Z = AW'(MAX_X * MAX_Y);
	localparam logic [8:0] LIM_X = 9'(MAX_X);
	localparam logic [8:0] LIM_Y = 9'(MAX_Y);
	localparam logic [8:0] LIM_Z = 9'(MAX_Z);

	function automatic logic below(input logic [8:0] v, input logic [SIZE_W-1:0] s,
		input logic [8:0] m);
		below = (v < {3'b0, s}) && (v < m);
	endfunction

	state_t state_q, state_d;

	logic [COEF_W-1:0] step_q, inv_x_q, inv_y_q, inv_z_q;
	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

	logic [2:0] rd_cnt_q;
	logic [1:0] iss_cnt_q, rcv_cnt_q;
	logic       done_q;

	logic [COORD_W-1:0]       x_q, y_q, z_q;
	logic [AW-1:0]            center_addr_q;
	logic signed [VAL_W-1:0]  cval_q;
	logic signed [DIFF_W-1:0] diff_x_q, diff_y_q, diff_z_q;
	logic signed [RES_W-1:0]  lap_q;
	logic signed [VAL_W-1:0]  new_value_q;
	logic                     status_q;

	logic              in_inside;
	logic [AW-1:0]     in_addr;
	logic [7:0]        nvalid;
	logic [AW-1:0]     nb_addr;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_addr;
	logic [WORD_W-1:0] mem_rdata;
	logic signed [VAL_W-1:0] rd_val;
	logic [KIND_W-1:0] rd_kind;
	logic [2:0]        nb_idx;
	logic [1:0]        axis;
	logic              nb_use;
	logic signed [VAL_W:0] n_minus_c;

	logic signed [DIFF_W-1:0] diff_sel;
	logic [DIFF_W-1:0]        diff_mag;
	logic [RES_W-1:0]         lap_abs;
	logic [MAG_W-1:0]         lap_mag;
	logic signed [RES_W:0]    sum;
	logic [VAL_W-1:0]         sat_val;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	logic              res_set;
	logic [VAL_W-1:0]  res_val;
	logic              res_stat;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= RST_STEP;
			inv_x_q  <= RST_INV;
			inv_y_q  <= RST_INV;
			inv_z_q  <= RST_INV;
			size_x_q <= RST_SIZE;
			size_y_q <= RST_SIZE;
			size_z_q <= RST_SIZE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STEP:   step_q   <= cfg_data;
				CFG_INV_X:  inv_x_q  <= cfg_data;
				CFG_INV_Y:  inv_y_q  <= cfg_data;
				CFG_INV_Z:  inv_z_q  <= cfg_data;
				CFG_SIZE_X: size_x_q <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_Y: size_y_q <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_Z: size_z_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// addressing
	assign in_inside = below(9'(cell_x), size_x_q, LIM_X) && below(9'(cell_y), size_y_q, LIM_Y)
		&& below(9'(cell_z), size_z_q, LIM_Z);
	assign in_addr = AW'(AW'(cell_z) * STRIDE_Z) + AW'(AW'(cell_y) * STRIDE_Y) + AW'(cell_x);

	assign nvalid[0] = (x_q != '0);
	assign nvalid[1] = below(9'(x_q) + 9'd1, size_x_q, LIM_X);
	assign nvalid[2] = (y_q != '0);
	assign nvalid[3] = below(9'(y_q) + 9'd1, size_y_q, LIM_Y);
	assign nvalid[4] = (z_q != '0);
	assign nvalid[5] = below(9'(z_q) + 9'd1, size_z_q, LIM_Z);
	assign nvalid[7:6] = 2'b00;

	always_comb begin
		unique case (rd_cnt_q)
			3'd0:    nb_addr = center_addr_q - STRIDE_X;
			3'd1:    nb_addr = center_addr_q + STRIDE_X;
			3'd2:    nb_addr = center_addr_q - STRIDE_Y;
			3'd3:    nb_addr = center_addr_q + STRIDE_Y;
			3'd4:    nb_addr = center_addr_q - STRIDE_Z;
			3'd5:    nb_addr = center_addr_q + STRIDE_Z;
			default: nb_addr = center_addr_q;
		endcase
	end

	mldf_grid_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata({cell_kind, cell_value}),
		.rdata(mem_rdata)
	);

	assign rd_val    = $signed(mem_rdata[VAL_W-1:0]);
	assign rd_kind   = mem_rdata[WORD_W-1:VAL_W];
	assign nb_idx    = rd_cnt_q - 3'd1;
	assign axis      = nb_idx[2:1];
	assign nb_use    = nvalid[nb_idx] && (rd_kind == KIND_FLUID);
	assign n_minus_c = {rd_val[VAL_W-1], rd_val} - {cval_q[VAL_W-1], cval_q};

	// multiplier operands
	always_comb begin
		unique case (iss_cnt_q)
			2'd0:    diff_sel = diff_x_q;
			2'd1:    diff_sel = diff_y_q;
			default: diff_sel = diff_z_q;
		endcase
		diff_mag = diff_sel[DIFF_W-1] ? DIFF_W'(-diff_sel) : DIFF_W'(diff_sel);
		lap_abs  = lap_q[RES_W-1] ? RES_W'(-lap_q) : RES_W'(lap_q);
		lap_mag  = (lap_abs > RES_W'(LAP_CAP)) ? LAP_CAP : lap_abs[MAG_W-1:0];
	end

	mldf_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mul_req),
		.rsp   (mul_rsp)
	);

	// final add and saturation
	always_comb begin
		sum = {{(RES_W-VAL_W+1){cval_q[VAL_W-1]}}, cval_q}
			+ {mul_rsp.value[RES_W-1], mul_rsp.value};
		if (!sum[RES_W] && (|sum[RES_W-1:VAL_W-1])) begin
			sat_val = 32'h7FFF_FFFF;
		end else if (sum[RES_W] && !(&sum[RES_W-1:VAL_W-1])) begin
			sat_val = 32'h8000_0000;
		end else begin
			sat_val = sum[VAL_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = in_addr;
		mul_req  = '0;
		res_set  = 1'b0;
		res_val  = '0;
		res_stat = STATUS_OK;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_type == REQ_WRITE) begin
						mem_we = in_inside;
					end else if (in_inside) begin
						mem_re  = 1'b1;
						state_d = ST_READ;
					end else begin
						res_set  = 1'b1;
						res_stat = STATUS_RANGE;
					end
				end
			end
			ST_READ: begin
				mem_addr = nb_addr;
				mem_re   = nvalid[rd_cnt_q];
				if (rd_cnt_q == 3'd0) begin
					if (rd_kind != KIND_FLUID) begin
						res_set = 1'b1;
						res_val = rd_val;
						state_d = ST_IDLE;
					end
				end else if (rd_cnt_q == 3'd6) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				mul_req.start = (iss_cnt_q != 2'd3);
				mul_req.neg   = diff_sel[DIFF_W-1];
				mul_req.mag   = MAG_W'(diff_mag);
				unique case (iss_cnt_q)
					2'd0:    mul_req.coef = inv_x_q;
					2'd1:    mul_req.coef = inv_y_q;
					default: mul_req.coef = inv_z_q;
				endcase
				if (mul_rsp.done && (rcv_cnt_q == 2'd2)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				mul_req.start = 1'b1;
				mul_req.neg   = lap_q[RES_W-1];
				mul_req.mag   = lap_mag;
				mul_req.coef  = step_q;
				state_d       = ST_WAIT;
			end
			ST_WAIT: begin
				if (mul_rsp.done) begin
					res_set = 1'b1;
					res_val = sat_val;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			iss_cnt_q <= '0;
			rcv_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= res_set;
			if (state_q == ST_IDLE) begin
				rd_cnt_q  <= '0;
				iss_cnt_q <= '0;
				rcv_cnt_q <= '0;
			end else begin
				if (state_q == ST_READ) begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
				end
				if ((state_q == ST_MUL) && mul_req.start) begin
					iss_cnt_q <= iss_cnt_q + 2'd1;
				end
				if ((state_q == ST_MUL) && mul_rsp.done) begin
					rcv_cnt_q <= rcv_cnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			x_q           <= cell_x;
			y_q           <= cell_y;
			z_q           <= cell_z;
			center_addr_q <= in_addr;
			diff_x_q      <= '0;
			diff_y_q      <= '0;
			diff_z_q      <= '0;
			lap_q         <= '0;
		end
		if (state_q == ST_READ) begin
			if (rd_cnt_q == 3'd0) begin
				cval_q <= rd_val;
			end else if (nb_use) begin
				unique case (axis)
					2'd0:    diff_x_q <= diff_x_q + {n_minus_c[VAL_W], n_minus_c};
					2'd1:    diff_y_q <= diff_y_q + {n_minus_c[VAL_W], n_minus_c};
					2'd2:    diff_z_q <= diff_z_q + {n_minus_c[VAL_W], n_minus_c};
					default: ;
				endcase
			end
		end
		if ((state_q == ST_MUL) && mul_rsp.done) begin
			lap_q <= lap_q + mul_rsp.value;
		end
		if (res_set) begin
			new_value_q <= res_val;
			status_q    <= res_stat;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign new_value = new_value_q;
	assign status    = status_q;

	a_rsp_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_MUL) || (state_q == ST_WAIT))
		else $error("multiplier result outside product phase");

	a_rcv_le_iss: assert property (@(posedge clk) disable iff (!arst_n)
		rcv_cnt_q <= iss_cnt_q)
		else $error("more products received than issued");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == REQ_WRITE)) |=> !done)
		else $error("result strobed after a write");

	a_range_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == REQ_QUERY) && !in_inside)
		|=> done && (status == STATUS_RANGE) && (new_value == '0))
		else $error("out-of-range query not flagged");

endmodule

>>> sv/mldf_grid_mem.sv
// Single-port grid store: value and kind per cell, registered read.
module mldf_grid_mem #(
	parameter int DEPTH = mldf_pkg::DEF_MAX_X * mldf_pkg::DEF_MAX_Y * mldf_pkg::DEF_MAX_Z,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic                        re,
	input  logic [AW-1:0]               addr,
	input  logic [mldf_pkg::WORD_W-1:0] wdata,
	output logic [mldf_pkg::WORD_W-1:0] rdata
);
	import mldf_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/mldf_mul.sv
// Four-stage Q16.16 magnitude multiplier with round-half-away and cap.
module mldf_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  mldf_pkg::mul_req_t req,
	output mldf_pkg::mul_rsp_t rsp
);
	import mldf_pkg::*;

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    neg_s1, neg_s2, neg_s3;
	logic [LO_W+COEF_W-1:0]  lo_s1, lo_s2;
	logic [HI_W-1:0]         hi_mag_s1;
	logic [COEF_W-1:0]       coef_s1;
	logic [HI_W+COEF_W-1:0]  hi_s2;
	logic [FULL_W-1:0]       full_s3;
	logic signed [RES_W-1:0] value_s4;

	logic [FULL_W-1:0]       rnd_sum;
	logic [RND_W-1:0]        rnd;
	logic [RES_W-1:0]        capped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		rnd_sum = full_s3 + ROUND_HALF;
		rnd     = rnd_sum[FULL_W-1:FRAC_W];
		capped  = (rnd > PROD_CAP) ? RES_W'(PROD_CAP) : RES_W'(rnd);
	end

	always_ff @(posedge clk) begin
		lo_s1     <= (LO_W+COEF_W)'(req.mag[LO_W-1:0]) * (LO_W+COEF_W)'(req.coef);
		hi_mag_s1 <= req.mag[MAG_W-1:LO_W];
		coef_s1   <= req.coef;
		neg_s1    <= req.neg;

		lo_s2     <= lo_s1;
		hi_s2     <= (HI_W+COEF_W)'(hi_mag_s1) * (HI_W+COEF_W)'(coef_s1);
		neg_s2    <= neg_s1;

		full_s3   <= FULL_W'(lo_s2) + {hi_s2, {LO_W{1'b0}}};
		neg_s3    <= neg_s2;

		value_s4  <= neg_s3 ? -$signed(capped) : $signed(capped);
	end

	assign rsp.done  = v_s4;
	assign rsp.value = value_s4;

endmodule
